>>> hdl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; a clock named clock and a reset named reset must be in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define RDF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RDF_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/rdf_pkg.sv
// shared types, widths, register indexes and reset values
// of the roi depth follow controller; no dependencies
package rdf_pkg;

   localparam int COORD_W    = 10;
   localparam int DEPTH_W    = 16;
   localparam int FW_W       = 11;
   localparam int IDX_W      = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SPEED_W    = 11;
   localparam int RATE_W     = 10;

   localparam int MAX_COLUMN_DEF = 320;
   localparam int MAX_ROW_DEF    = 240;

   localparam int SPEED_LIMIT = 1000;
   localparam int RATE_LIMIT  = 300;

   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
   localparam logic [IDX_W-1:0] REG_TARGET      = 3'd1;
   localparam logic [IDX_W-1:0] REG_DEADBAND    = 3'd2;
   localparam logic [IDX_W-1:0] REG_CENTER_X    = 3'd3;
   localparam logic [IDX_W-1:0] REG_CENTER_Y    = 3'd4;

   localparam logic [FW_W-1:0]    FRAME_WIDTH_RST = 11'd320;
   localparam logic [DEPTH_W-1:0] TARGET_RST      = 16'd1000;
   localparam logic [DEPTH_W-1:0] DEADBAND_RST    = 16'd200;
   localparam logic [COORD_W-1:0] CENTER_X_RST    = 10'd160;
   localparam logic [COORD_W-1:0] CENTER_Y_RST    = 10'd120;

   localparam logic CMD_BOX   = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   typedef struct packed {
      logic [FW_W-1:0]    frame_width;
      logic [DEPTH_W-1:0] target_depth_mm;
      logic [DEPTH_W-1:0] deadband_mm;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
   } cfg_type;

   typedef struct packed {
      logic load_box;
      logic lost_box;
      logic pixel;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic frame_ignored;
   } dp_stat_type;

endpackage

>>> hdl/rdf_if.sv
// valid/ready channel interfaces: request items, result items, register writes
// depends on rdf_pkg
interface rdf_req_if import rdf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [COORD_W-1:0] box_left;
   logic [COORD_W-1:0] box_top;
   logic [COORD_W-1:0] box_right;
   logic [COORD_W-1:0] box_bottom;
   logic               object_lost;
   logic [DEPTH_W-1:0] depth_mm;
   logic               depth_valid;
   logic               last_pixel;

   modport source (output valid, cmd, box_left, box_top, box_right, box_bottom,
                   object_lost, depth_mm, depth_valid, last_pixel, input ready);
   modport sink   (input valid, cmd, box_left, box_top, box_right, box_bottom,
                   object_lost, depth_mm, depth_valid, last_pixel, output ready);
endinterface

interface rdf_rsp_if import rdf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] speed_forward;
   logic signed [RATE_W-1:0]  turn_rate;
   logic signed [RATE_W-1:0]  climb_rate;
   logic [DEPTH_W-1:0]        nearest_depth;
   logic                      depth_found;

   modport source (output valid, speed_forward, turn_rate, climb_rate, nearest_depth,
                   depth_found, input ready);
   modport sink   (input valid, speed_forward, turn_rate, climb_rate, nearest_depth,
                   depth_found, output ready);
endinterface

interface rdf_csr_if import rdf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [IDX_W-1:0]      index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/rdf_regs.sv
// configuration register file, written over the csr channel
// depends on rdf_pkg
module rdf_regs import rdf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  csr_ready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: cfg_in.frame_width     = csr_data[FW_W-1:0];
            REG_TARGET:      cfg_in.target_depth_mm = csr_data[DEPTH_W-1:0];
            REG_DEADBAND:    cfg_in.deadband_mm     = csr_data[DEPTH_W-1:0];
            REG_CENTER_X:    cfg_in.center_x        = csr_data[COORD_W-1:0];
            REG_CENTER_Y:    cfg_in.center_y        = csr_data[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= FRAME_WIDTH_RST;
         cfg_ff.target_depth_mm <= TARGET_RST;
         cfg_ff.deadband_mm     <= DEADBAND_RST;
         cfg_ff.center_x        <= CENTER_X_RST;
         cfg_ff.center_y        <= CENTER_Y_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

>>> hdl/rdf_ctrl.sv
// controller: input handshake, result slot ownership and the finish state
// depends on rdf_pkg
module rdf_ctrl import rdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_cmd,
   input  logic        req_object_lost,
   input  logic        req_last_pixel,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic ST_RUN    = 1'b0;
   localparam logic ST_FINISH = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   // ready in the run state while the result slot is free, or drains this cycle
   assign req_ready = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.load_box = accept && (req_cmd == CMD_BOX) && !req_object_lost;
      cmd.lost_box = accept && (req_cmd == CMD_BOX) && req_object_lost;
      cmd.pixel    = accept && (req_cmd == CMD_PIXEL);
      cmd.emit     = (state_ff == ST_FINISH);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (cmd.pixel && req_last_pixel && !stat.frame_ignored) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.lost_box || cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/rdf_dpath.sv
// datapath: box registers, raster counters, nearest depth and the command math
// depends on rdf_pkg; driven by rdf_ctrl commands
module rdf_dpath import rdf_pkg::*; #(
   parameter int MAX_COLUMN = MAX_COLUMN_DEF,
   parameter int MAX_ROW    = MAX_ROW_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  dp_cmd_type                cmd,
   input  logic [COORD_W-1:0]        box_left,
   input  logic [COORD_W-1:0]        box_top,
   input  logic [COORD_W-1:0]        box_right,
   input  logic [COORD_W-1:0]        box_bottom,
   input  logic [DEPTH_W-1:0]        depth_mm,
   input  logic                      depth_valid,
   input  logic                      last_pixel,
   output dp_stat_type               stat,
   output logic signed [SPEED_W-1:0] speed_forward,
   output logic signed [RATE_W-1:0]  turn_rate,
   output logic signed [RATE_W-1:0]  climb_rate,
   output logic [DEPTH_W-1:0]        nearest_depth,
   output logic                      depth_found
);

   localparam int DIFF_W = DEPTH_W + 1;
   localparam int SUM_W  = COORD_W + 1;
   localparam int SD_W   = COORD_W + 2;
   localparam int M5_W   = COORD_W + 3;

   localparam logic [COORD_W-1:0]       COL_HI   = COORD_W'(MAX_COLUMN);
   localparam logic [COORD_W-1:0]       ROW_HI   = COORD_W'(MAX_ROW);
   localparam logic signed [DIFF_W-1:0] DIFF_HI  = DIFF_W'(SPEED_LIMIT);
   localparam logic signed [DIFF_W-1:0] DIFF_LO  = -DIFF_W'(SPEED_LIMIT);
   localparam logic signed [SPEED_W-1:0] SPD_MAX = SPEED_W'(SPEED_LIMIT);
   localparam logic signed [RATE_W-1:0] RATE_MAX = RATE_W'(RATE_LIMIT);

   function automatic logic [COORD_W-1:0] clamp_coord(
      input logic [COORD_W-1:0] v,
      input logic [COORD_W-1:0] hi
   );
      logic [COORD_W-1:0] r;
      priority if (v == '0) begin
         r = COORD_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // sign of trunc((centre - mid) * 5 / centre) as a full-scale rate
   function automatic logic signed [RATE_W-1:0] steer(
      input logic [COORD_W-1:0] lo,
      input logic [COORD_W-1:0] hi,
      input logic [COORD_W-1:0] centre
   );
      logic [SUM_W-1:0]       sum;
      logic [COORD_W-1:0]     mid;
      logic signed [SD_W-1:0] diff;
      logic signed [SD_W-1:0] neg;
      logic [SUM_W-1:0]       mag;
      logic [M5_W-1:0]        mag5;
      logic [COORD_W-1:0]     divisor;
      logic signed [RATE_W-1:0] r;
      sum     = {1'b0, lo} + {1'b0, hi};
      mid     = sum[SUM_W-1:1];
      diff    = $signed({2'b00, centre}) - $signed({2'b00, mid});
      neg     = -diff;
      mag     = diff[SD_W-1] ? neg[SUM_W-1:0] : diff[SUM_W-1:0];
      mag5    = {mag, 1'b0, 1'b0} + {2'b00, mag};
      divisor = (centre == '0) ? COORD_W'(1) : centre;
      if (mag5 >= {3'b000, divisor}) begin
         r = diff[SD_W-1] ? -RATE_MAX : RATE_MAX;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   logic [COORD_W-1:0] left_ff, left_in, top_ff, top_in;
   logic [COORD_W-1:0] right_ff, right_in, bottom_ff, bottom_in;
   logic [COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [DEPTH_W-1:0] min_ff, min_in;
   logic               found_ff, found_in;
   logic               ignored_ff, ignored_in;

   logic signed [SPEED_W-1:0] spd_ff, spd_in;
   logic signed [RATE_W-1:0]  turn_ff, turn_in, climb_ff, climb_in;
   logic [DEPTH_W-1:0]        near_ff, near_in;
   logic                      fnd_ff, fnd_in;

   logic                      in_box;
   logic                      row_end;
   logic signed [DIFF_W-1:0]  err;
   logic signed [SPEED_W-1:0] spd_clamp;
   logic signed [SPEED_W-1:0] spd_calc;

   assign in_box = depth_valid && (col_ff >= left_ff) && (col_ff <= right_ff) &&
                   (row_ff >= top_ff) && (row_ff <= bottom_ff);
   assign row_end = (({1'b0, col_ff} + FW_W'(1)) >= cfg.frame_width) || (col_ff == '1);

   // forward speed from the nearest depth
   always_comb begin
      err = $signed({1'b0, min_ff}) - $signed({1'b0, cfg.target_depth_mm});
      priority if (err > DIFF_HI) begin
         spd_clamp = SPD_MAX;
      end else if (err < DIFF_LO) begin
         spd_clamp = -SPD_MAX;
      end else begin
         spd_clamp = err[SPEED_W-1:0];
      end
      priority if (!found_ff) begin
         spd_calc = SPD_MAX;
      end else if ((spd_clamp > 0) &&
                   ({{(DEPTH_W-SPEED_W){1'b0}}, spd_clamp} < cfg.deadband_mm)) begin
         spd_calc = '0;
      end else begin
         spd_calc = spd_clamp;
      end
   end

   always_comb begin
      left_in    = left_ff;
      top_in     = top_ff;
      right_in   = right_ff;
      bottom_in  = bottom_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      min_in     = min_ff;
      found_in   = found_ff;
      ignored_in = ignored_ff;
      spd_in     = spd_ff;
      turn_in    = turn_ff;
      climb_in   = climb_ff;
      near_in    = near_ff;
      fnd_in     = fnd_ff;
      priority if (cmd.load_box) begin
         left_in    = clamp_coord(box_left, COL_HI);
         top_in     = clamp_coord(box_top, ROW_HI);
         right_in   = clamp_coord(box_right, COL_HI);
         bottom_in  = clamp_coord(box_bottom, ROW_HI);
         ignored_in = 1'b0;
         col_in     = '0;
         row_in     = '0;
         min_in     = '1;
         found_in   = 1'b0;
      end else if (cmd.lost_box) begin
         ignored_in = 1'b1;
         col_in     = '0;
         row_in     = '0;
         min_in     = '1;
         found_in   = 1'b0;
         spd_in     = '0;
         turn_in    = '0;
         climb_in   = '0;
         near_in    = '0;
         fnd_in     = 1'b0;
      end else if (cmd.pixel) begin
         if (in_box) begin
            found_in = 1'b1;
            if (depth_mm < min_ff) begin
               min_in = depth_mm;
            end
         end
         if (last_pixel) begin
            col_in = '0;
            row_in = '0;
            if (ignored_ff) begin
               min_in   = '1;
               found_in = 1'b0;
            end
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + COORD_W'(1);
         end else begin
            col_in = col_ff + COORD_W'(1);
         end
      end else if (cmd.emit) begin
         spd_in   = spd_calc;
         turn_in  = steer(left_ff, right_ff, cfg.center_x);
         climb_in = steer(top_ff, bottom_ff, cfg.center_y);
         near_in  = found_ff ? min_ff : '0;
         fnd_in   = found_ff;
         min_in   = '1;
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         top_ff     <= '0;
         right_ff   <= '0;
         bottom_ff  <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         min_ff     <= '1;
         found_ff   <= 1'b0;
         ignored_ff <= 1'b0;
      end else begin
         left_ff    <= left_in;
         top_ff     <= top_in;
         right_ff   <= right_in;
         bottom_ff  <= bottom_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         min_ff     <= min_in;
         found_ff   <= found_in;
         ignored_ff <= ignored_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      spd_ff   <= spd_in;
      turn_ff  <= turn_in;
      climb_ff <= climb_in;
      near_ff  <= near_in;
      fnd_ff   <= fnd_in;
   end

   assign stat.frame_ignored = ignored_ff;
   assign speed_forward      = spd_ff;
   assign turn_rate          = turn_ff;
   assign climb_rate         = climb_ff;
   assign nearest_depth      = near_ff;
   assign depth_found        = fnd_ff;

endmodule

>>> hdl/roi_depth_follow_controller.sv
// channel | dir | item contents
// req_chan | in  | cmd, box_left/top/right/bottom, object_lost, depth_mm, depth_valid, last_pixel
// rsp_chan | out | speed_forward, turn_rate, climb_rate, nearest_depth, depth_found
// csr_chan | in  | register index, write data (always ready)
//
// box loads and depth pixels are taken one per cycle while the input is not stalled
// after the last pixel of a tracked frame the input pauses in a finish state, spent forming the result
// the input stalls while an undelivered result holds the single output register
// reset restores the register defaults and clears the box to (0,0)-(0,0)
// top level: rdf_regs, rdf_ctrl and rdf_dpath; depends on rdf_pkg and rdf_if
module roi_depth_follow_controller import rdf_pkg::*; #(
   parameter int MAX_COLUMN = MAX_COLUMN_DEF,
   parameter int MAX_ROW    = MAX_ROW_DEF
) (
   input logic        clock,
   input logic        reset,
   rdf_req_if.sink    req_chan,
   rdf_rsp_if.source  rsp_chan,
   rdf_csr_if.sink    csr_chan
);

   cfg_type     cfg;
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   rdf_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .csr_ready (csr_chan.ready),
      .cfg       (cfg)
   );

   rdf_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_cmd         (req_chan.cmd),
      .req_object_lost (req_chan.object_lost),
      .req_last_pixel  (req_chan.last_pixel),
      .req_ready       (req_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .stat            (dp_stat),
      .cmd             (dp_cmd)
   );

   rdf_dpath #(
      .MAX_COLUMN (MAX_COLUMN),
      .MAX_ROW    (MAX_ROW)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (dp_cmd),
      .box_left      (req_chan.box_left),
      .box_top       (req_chan.box_top),
      .box_right     (req_chan.box_right),
      .box_bottom    (req_chan.box_bottom),
      .depth_mm      (req_chan.depth_mm),
      .depth_valid   (req_chan.depth_valid),
      .last_pixel    (req_chan.last_pixel),
      .stat          (dp_stat),
      .speed_forward (rsp_chan.speed_forward),
      .turn_rate     (rsp_chan.turn_rate),
      .climb_rate    (rsp_chan.climb_rate),
      .nearest_depth (rsp_chan.nearest_depth),
      .depth_found   (rsp_chan.depth_found)
   );

endmodule

>>> hdl/rdf_checker.sv
// port-level checks of roi_depth_follow_controller, attached by bind
// depends on rdf_pkg and assert_macros.svh
`include "assert_macros.svh"

module rdf_checker import rdf_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_cmd,
   input logic                      req_object_lost,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [SPEED_W-1:0] speed_forward,
   input logic signed [RATE_W-1:0]  turn_rate,
   input logic signed [RATE_W-1:0]  climb_rate,
   input logic [DEPTH_W-1:0]        nearest_depth,
   input logic                      depth_found
);

   localparam logic signed [RATE_W-1:0] RATE_MAX = RATE_W'(RATE_LIMIT);

   // a waiting result holds still
   `RDF_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(speed_forward) && $stable(turn_rate) && $stable(climb_rate) && $stable(nearest_depth) && $stable(depth_found), "result changed while stalled")

   // a lost box answers in the next cycle with an all-zero command
   `RDF_ASSERT(a_lost_zero, req_valid && req_ready && req_cmd == CMD_BOX && req_object_lost |=> rsp_valid && speed_forward == '0 && turn_rate == '0 && climb_rate == '0 && nearest_depth == '0 && !depth_found, "lost box gave no zero command")

   // no valid pixel means no nearest depth
   `RDF_ASSERT(a_empty_box, rsp_valid && !depth_found |-> nearest_depth == '0, "empty box reports a depth")

   // steering is full scale or zero
   `RDF_ASSERT(a_steer_levels, rsp_valid |-> (turn_rate == '0 || turn_rate == RATE_MAX || turn_rate == -RATE_MAX) && (climb_rate == '0 || climb_rate == RATE_MAX || climb_rate == -RATE_MAX), "steering outside its three levels")

endmodule

bind roi_depth_follow_controller rdf_checker u_rdf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_cmd         (req_chan.cmd),
   .req_object_lost (req_chan.object_lost),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .speed_forward   (rsp_chan.speed_forward),
   .turn_rate       (rsp_chan.turn_rate),
   .climb_rate      (rsp_chan.climb_rate),
   .nearest_depth   (rsp_chan.nearest_depth),
   .depth_found     (rsp_chan.depth_found)
);
